// ===== hw/rtl/fspr_pkg.sv =====
// fan speed pi regulator: shared types, constants and rounding helper
`default_nettype none

package fspr_pkg;

  // duty scale, Q8 percent
  localparam logic [14:0] FullDuty  = 15'd25600;
  localparam logic [14:0] OnePct    = 15'd256;
  localparam logic [14:0] JumpLimit = 15'd1280;

  // sample timing and tach option
  localparam logic [31:0] SamplePeriodMs = 32'd1000;
  localparam logic        TachPresent    = 1'b1;

  // ema weight of one in Q8
  localparam logic [8:0] AlphaOne = 9'd256;

  // register reset values
  localparam logic [15:0] PropGainRst        = 16'd0;
  localparam logic [15:0] IntegralGainRst    = 16'd0;
  localparam logic [14:0] IntegralLimitRst   = 15'd5120;
  localparam logic [14:0] MinOnDutyRst       = 15'd3072;
  localparam logic [6:0]  UnderspeedPctRst   = 7'd15;
  localparam logic [15:0] FaultHoldMsRst     = 16'd5000;
  localparam logic [15:0] StartupGraceMsRst  = 16'd5000;
  localparam logic [8:0]  SmoothingAlphaRst  = 9'd64;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    RegPropGain       = 3'd0,
    RegIntegralGain   = 3'd1,
    RegIntegralLimit  = 3'd2,
    RegMinOnDuty      = 3'd3,
    RegUnderspeedPct  = 3'd4,
    RegFaultHoldMs    = 3'd5,
    RegStartupGraceMs = 3'd6,
    RegSmoothingAlpha = 3'd7
  } reg_idx_e;

  // configuration seen by the datapath
  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integral_gain;
    logic [14:0] integral_limit;
    logic [14:0] min_on_duty;
    logic [6:0]  underspeed_pct;
    logic [15:0] fault_hold_ms;
    logic [15:0] startup_grace_ms;
    logic [8:0]  smoothing_alpha;
  } cfg_t;

  // one input word
  typedef struct packed {
    logic [31:0] now_ms;
    logic [14:0] commanded_duty;
    logic [15:0] target_rpm;
    logic [15:0] tach_rpm;
    logic        tach_valid;
  } item_t;

  // one result word
  typedef struct packed {
    logic [14:0] duty_out;
    logic [15:0] report_rpm;
    logic        rpm_known;
    logic        speed_fault;
  } result_t;

  // divide by 256, round to nearest, half away from zero
  function automatic logic signed [27:0] round_q8(input logic signed [35:0] v);
    logic signed [35:0] mag;
    logic signed [27:0] q;
    mag = (v >= 36'sd0) ? (v + 36'sd128) : (-v + 36'sd128);
    q   = $signed(mag[35:8]);
    return (v >= 36'sd0) ? q : -q;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fspr_regs.sv =====
// fan speed pi regulator: apb configuration registers
`default_nettype none

module fspr_regs
  import fspr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain        <= PropGainRst;
      cfg_q.integral_gain    <= IntegralGainRst;
      cfg_q.integral_limit   <= IntegralLimitRst;
      cfg_q.min_on_duty      <= MinOnDutyRst;
      cfg_q.underspeed_pct   <= UnderspeedPctRst;
      cfg_q.fault_hold_ms    <= FaultHoldMsRst;
      cfg_q.startup_grace_ms <= StartupGraceMsRst;
      cfg_q.smoothing_alpha  <= SmoothingAlphaRst;
    end else if (wr_en) begin
      case (idx)
        RegPropGain:       cfg_q.prop_gain        <= pwdata[15:0];
        RegIntegralGain:   cfg_q.integral_gain    <= pwdata[15:0];
        RegIntegralLimit:  cfg_q.integral_limit   <= pwdata[14:0];
        RegMinOnDuty:      cfg_q.min_on_duty      <= pwdata[14:0];
        RegUnderspeedPct:  cfg_q.underspeed_pct   <= pwdata[6:0];
        RegFaultHoldMs:    cfg_q.fault_hold_ms    <= pwdata[15:0];
        RegStartupGraceMs: cfg_q.startup_grace_ms <= pwdata[15:0];
        RegSmoothingAlpha: cfg_q.smoothing_alpha  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      RegPropGain:       prdata = {16'd0, cfg_q.prop_gain};
      RegIntegralGain:   prdata = {16'd0, cfg_q.integral_gain};
      RegIntegralLimit:  prdata = {17'd0, cfg_q.integral_limit};
      RegMinOnDuty:      prdata = {17'd0, cfg_q.min_on_duty};
      RegUnderspeedPct:  prdata = {25'd0, cfg_q.underspeed_pct};
      RegFaultHoldMs:    prdata = {16'd0, cfg_q.fault_hold_ms};
      RegStartupGraceMs: prdata = {16'd0, cfg_q.startup_grace_ms};
      RegSmoothingAlpha: prdata = {23'd0, cfg_q.smoothing_alpha};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fspr_core.sv =====
// fan speed pi regulator: loop state and single-pass control datapath
`default_nettype none

module fspr_core
  import fspr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_en_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    res_o
);

  // loop state
  logic signed [15:0] integ_q, integ_d;
  logic [14:0]        corr_q, corr_d;
  logic [14:0]        prev_cmd_q;
  logic               cmd_seen_q;
  logic [31:0]        last_sample_q;
  logic [31:0]        grace_end_q, grace_end_d;
  logic [31:0]        short_start_q, short_start_d;
  logic               short_active_q, short_active_d;
  logic               meas_seen_q, meas_seen_d;
  logic [23:0]        smoothed_q, smoothed_d;

  // command conditioning and restart detect
  logic [14:0]        cmd_sat;
  logic [14:0]        cmd_diff;
  logic               restart;
  logic signed [15:0] integ_base;
  logic [14:0]        corr_base;
  logic [31:0]        short_start_base;
  logic               short_active_base;

  // sampling
  logic [31:0] since_sample;
  logic        sample_due;
  logic        take;

  // ema
  logic [8:0]         alpha_sat;
  logic signed [24:0] ema_diff;
  logic signed [35:0] ema_prod;
  logic signed [27:0] ema_step;

  // pi
  logic               loop_off;
  logic signed [16:0] err;
  logic signed [35:0] i_prod, p_prod;
  logic signed [27:0] i_step, p_step;
  logic signed [28:0] i_sum, lim;
  logic signed [15:0] integ_sat;
  logic signed [29:0] v_sum;
  logic [14:0]        corr_calc;

  // under-speed
  logic [22:0] err_x100, pct_tgt;
  logic        under;
  logic [31:0] since_grace;
  logic        past_grace;

  // output
  logic [31:0] since_short;
  logic [14:0] duty;
  logic [23:0] rpm_round;

  assign cmd_sat  = (item_i.commanded_duty > FullDuty) ? FullDuty : item_i.commanded_duty;
  assign cmd_diff = (cmd_sat > prev_cmd_q) ? (cmd_sat - prev_cmd_q) : (prev_cmd_q - cmd_sat);
  assign restart  = !cmd_seen_q || (cmd_diff > JumpLimit);

  // state after an optional loop restart
  assign integ_base        = restart ? 16'sd0 : integ_q;
  assign corr_base         = restart ? cmd_sat : corr_q;
  assign grace_end_d       = restart ? (item_i.now_ms + {16'd0, cfg_i.startup_grace_ms})
                                     : grace_end_q;
  assign short_start_base  = restart ? 32'd0 : short_start_q;
  assign short_active_base = restart ? 1'b0 : short_active_q;

  assign since_sample = item_i.now_ms - last_sample_q;
  assign sample_due   = TachPresent && (since_sample >= SamplePeriodMs);
  assign take         = sample_due && item_i.tach_valid;

  // ema of measured rpm, Q8
  assign alpha_sat = (cfg_i.smoothing_alpha > AlphaOne) ? AlphaOne : cfg_i.smoothing_alpha;
  assign ema_diff  = $signed({1'b0, item_i.tach_rpm, 8'd0}) - $signed({1'b0, smoothed_q});
  assign ema_prod  = $signed({1'b0, alpha_sat}) * ema_diff;
  assign ema_step  = round_q8(ema_prod);

  always_comb begin
    smoothed_d  = smoothed_q;
    meas_seen_d = meas_seen_q;
    if (take) begin
      meas_seen_d = 1'b1;
      if (meas_seen_q) begin
        smoothed_d = smoothed_q + ema_step[23:0];
      end else begin
        smoothed_d = {item_i.tach_rpm, 8'd0};
      end
    end
  end

  // p and i terms
  assign loop_off = (cmd_sat < OnePct) || (item_i.target_rpm == 16'd0);
  assign err      = $signed({1'b0, item_i.target_rpm}) - $signed({1'b0, item_i.tach_rpm});
  assign i_prod   = $signed({1'b0, cfg_i.integral_gain}) * err;
  assign p_prod   = $signed({1'b0, cfg_i.prop_gain}) * err;
  assign i_step   = round_q8(i_prod);
  assign p_step   = round_q8(p_prod);
  assign i_sum    = 29'(integ_base) + 29'(i_step);
  assign lim      = $signed({14'd0, cfg_i.integral_limit});

  // integral saturation
  always_comb begin
    if (i_sum > lim) begin
      integ_sat = 16'(lim);
    end else if (i_sum < -lim) begin
      integ_sat = 16'(-lim);
    end else begin
      integ_sat = 16'(i_sum);
    end
  end

  assign v_sum = $signed({15'd0, cmd_sat}) + 30'(p_step) + 30'(integ_sat);

  // clamp to min-on first, then full scale
  always_comb begin
    if (v_sum < $signed({15'd0, cfg_i.min_on_duty})) begin
      corr_calc = cfg_i.min_on_duty;
    end else begin
      corr_calc = v_sum[14:0];
    end
    if (v_sum > $signed({15'd0, FullDuty}) || corr_calc > FullDuty) begin
      corr_calc = FullDuty;
    end
  end

  // under-speed test and grace window
  assign err_x100    = {7'd0, err[15:0]} * 23'd100;
  assign pct_tgt     = {16'd0, cfg_i.underspeed_pct} * {7'd0, item_i.target_rpm};
  assign under       = (err > 17'sd0) && (err_x100 > pct_tgt);
  assign since_grace = item_i.now_ms - grace_end_d;
  assign past_grace  = !since_grace[31];

  // next loop state
  always_comb begin
    integ_d        = integ_base;
    corr_d         = corr_base;
    short_start_d  = short_start_base;
    short_active_d = short_active_base;
    if (take) begin
      if (loop_off) begin
        integ_d        = 16'sd0;
        short_active_d = 1'b0;
      end else begin
        integ_d = integ_sat;
        corr_d  = corr_calc;
        if (past_grace && under) begin
          if (!short_active_base) begin
            short_active_d = 1'b1;
            short_start_d  = item_i.now_ms;
          end
        end else begin
          short_active_d = 1'b0;
        end
      end
    end
  end

  // result word
  assign since_short = item_i.now_ms - short_start_d;
  assign rpm_round   = smoothed_d + 24'd128;

  always_comb begin
    if (cmd_sat < OnePct) begin
      duty = 15'd0;
    end else begin
      duty = TachPresent ? corr_d : cmd_sat;
      if (duty < cfg_i.min_on_duty) begin
        duty = cfg_i.min_on_duty;
      end
    end
  end

  assign res_o.duty_out    = duty;
  assign res_o.report_rpm  = meas_seen_d ? rpm_round[23:8] : 16'd0;
  assign res_o.rpm_known   = meas_seen_d;
  assign res_o.speed_fault = short_active_d && (since_short >= {16'd0, cfg_i.fault_hold_ms});

  // state update per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q        <= 16'sd0;
      corr_q         <= 15'd0;
      prev_cmd_q     <= 15'd0;
      cmd_seen_q     <= 1'b0;
      last_sample_q  <= 32'd0;
      grace_end_q    <= 32'd0;
      short_start_q  <= 32'd0;
      short_active_q <= 1'b0;
      meas_seen_q    <= 1'b0;
      smoothed_q     <= 24'd0;
    end else if (step_en_i) begin
      integ_q        <= integ_d;
      corr_q         <= corr_d;
      prev_cmd_q     <= cmd_sat;
      cmd_seen_q     <= 1'b1;
      grace_end_q    <= grace_end_d;
      short_start_q  <= short_start_d;
      short_active_q <= short_active_d;
      meas_seen_q    <= meas_seen_d;
      smoothed_q     <= smoothed_d;
      if (sample_due) begin
        last_sample_q <= item_i.now_ms;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fan_speed_pi_regulator.sv =====
// fan speed pi regulator: top level with word handshakes and apb port
//
// Input channel (in_valid_i/in_ready_o) takes one word per accepted edge:
// time stamp, commanded duty, target rpm and an optional tach sample.
// Output channel (out_valid_o/out_ready_i) gives one word per input word:
// PWM duty, smoothed rpm, rpm_known and speed_fault.
// An accepted word lands in an input register; when the result register is
// empty or being read, the whole control step runs and loads the result
// register, which drives out_valid_o. One word per cycle is sustained while
// out_ready_i stays high, as the PI / EMA step between the two registers is
// combinational. When the receiver stalls, the result register holds and
// the input register still takes one more word; in_ready_o drops only when both are full.
// Reset clears all loop state and loads the register defaults; the first
// word after reset always restarts the loop. The APB port writes with
// zero wait states and should only be used while the block is idle.
`default_nettype none

module fan_speed_pi_regulator
  import fspr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] now_ms_i,
  input  wire logic [14:0] commanded_duty_i,
  input  wire logic [15:0] target_rpm_i,
  input  wire logic [15:0] tach_rpm_i,
  input  wire logic        tach_valid_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [14:0]      duty_out_o,
  output logic [15:0]      report_rpm_o,
  output logic             rpm_known_o,
  output logic             speed_fault_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid_q;
  result_t res;
  result_t res_q;
  logic    res_valid_q;
  logic    advance;
  logic    in_fire;

  // handshake control
  assign advance    = item_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_valid_q <= 1'b1;
      end else if (advance) begin
        item_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.now_ms         <= now_ms_i;
      item_q.commanded_duty <= commanded_duty_i;
      item_q.target_rpm     <= target_rpm_i;
      item_q.tach_rpm       <= tach_rpm_i;
      item_q.tach_valid     <= tach_valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  fspr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fspr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign out_valid_o   = res_valid_q;
  assign duty_out_o    = res_q.duty_out;
  assign report_rpm_o  = res_q.report_rpm;
  assign rpm_known_o   = res_q.rpm_known;
  assign speed_fault_o = res_q.speed_fault;

endmodule

`default_nettype wire
